>>> design/bop_pkg.sv
// Shared constants, types and the arctangent table for the bond orientational
// order block. No dependencies.
package bop_pkg;

  localparam int DXW        = 24;  // Q12.12 bond offsets
  localparam int CW         = 27;  // CORDIC x/y datapath width
  localparam int ZW         = 19;  // CORDIC angle datapath width
  localparam int ANGW       = 17;  // binary angle, full turn = 2^17
  localparam int PSIW       = 18;  // Q1.16 results
  localparam int SUMW       = 22;  // cos/sin accumulators
  localparam int MAGW       = 17;  // Q1.16 squared magnitude
  localparam int SYMW       = 4;
  localparam int THRW       = 17;
  localparam int OCNTW      = 16;  // frame liquid count port width
  localparam int ATAN_IW    = 5;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 17;

  localparam logic [SYMW-1:0] SYM_RESET = 4'd6;
  localparam logic [THRW-1:0] THR_RESET = 17'd16384;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 27'sd10188014;

  localparam int MAX_NEIGHBOURS_DEF = 15;
  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF    = 16;

  localparam logic [CFG_AW-1:0] REG_SYMMETRY  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 1'd1;

  typedef struct packed {
    logic start;
    logic vectoring;
  } cordic_ctl_t;

  function automatic logic [ANGW-1:0] atan_lut(input logic [ATAN_IW-1:0] idx);
    logic [ANGW-1:0] r;
    case (idx)
      5'd0:  r = 17'd16384;
      5'd1:  r = 17'd9672;
      5'd2:  r = 17'd5110;
      5'd3:  r = 17'd2594;
      5'd4:  r = 17'd1302;
      5'd5:  r = 17'd652;
      5'd6:  r = 17'd326;
      5'd7:  r = 17'd163;
      5'd8:  r = 17'd81;
      5'd9:  r = 17'd41;
      5'd10: r = 17'd20;
      5'd11: r = 17'd10;
      5'd12: r = 17'd5;
      5'd13: r = 17'd3;
      5'd14: r = 17'd1;
      5'd15: r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/bond_orientational_order.sv
// Top level of the bond orientational order block: control sequencer,
// accumulators, serial squaring and output register. Uses bop_pkg, bop_cordic, bop_div.
//
// One bond at a time enters; the block takes a new item only when idle. For each bond
// the single iterative CORDIC unit runs once in vectoring mode for the bond angle and
// once in rotation mode for the cosine and sine of n times that angle. An item that
// ends a particle then passes through the bit-serial dividers that form the means and
// the bit-serial squaring of the magnitude. An item without a bond that ends nothing
// leaves the block idle. The result waits in an output register, so the next item can
// be taken while it is stalled, unless a second result is ready before the first one
// is taken.
module bond_orientational_order #(
  parameter int MAX_NEIGHBOURS = bop_pkg::MAX_NEIGHBOURS_DEF,
  parameter int CORDIC_STEPS   = bop_pkg::CORDIC_STEPS_DEF,
  parameter int COUNT_WIDTH    = bop_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bop_pkg::CFG_AW-1:0]        cfg_addr_i,
  input  logic [bop_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [bop_pkg::DXW-1:0]    bond_dx_i,
  input  logic signed [bop_pkg::DXW-1:0]    bond_dy_i,
  input  logic                              bond_valid_i,
  input  logic                              particle_last_i,
  input  logic                              frame_last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [bop_pkg::PSIW-1:0]   psi_real_o,
  output logic signed [bop_pkg::PSIW-1:0]   psi_imag_o,
  output logic [bop_pkg::MAGW-1:0]          psi_mag_sq_o,
  output logic                              is_liquid_o,
  output logic                              no_neighbours_o,
  output logic                              frame_end_o,
  output logic [bop_pkg::OCNTW-1:0]         frame_liquid_count_o
);

  localparam int BCW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int LCW = (COUNT_WIDTH >= 16) ? 16 : COUNT_WIDTH;
  localparam logic [LCW-1:0] LCAP = {LCW{1'b1}};
  localparam int DVW = bop_pkg::SUMW;
  localparam int SQW = bop_pkg::PSIW - 1;   // magnitude bits of a mean
  localparam int ACW = 2 * SQW + 1;
  localparam int SCW = $clog2(SQW + 1);
  localparam logic [SCW-1:0] SQ_LAST = SCW'(SQW - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_VEC  = 6'b000010,
    ST_ROT  = 6'b000100,
    ST_END  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_SQ   = 6'b100000
  } state_e;

  // Hand-off to the output register happens in ST_END after the squaring pass, or
  // directly for a particle without bonds; a flag marks that the squared sum is ready.
  state_e state_q, state_d;

  function automatic logic signed [bop_pkg::PSIW-1:0] clamp_unit(
    input logic signed [bop_pkg::CW-1:0] v);
    logic signed [bop_pkg::CW-1:0] w;
    logic signed [bop_pkg::PSIW-1:0] r;
    w = (v + 27'sd128) >>> 8;
    if (w > 27'sd65536) r = 18'sd65536;
    else if (w < -27'sd65536) r = -18'sd65536;
    else r = bop_pkg::PSIW'(w);
    return r;
  endfunction

  logic [bop_pkg::SYMW-1:0] sym_q;
  logic [bop_pkg::THRW-1:0] thr_q;
  logic signed [bop_pkg::SUMW-1:0] sre_q, sre_d, sim_q, sim_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic [LCW-1:0] lcnt_q, lcnt_d, lnew;
  logic last_q, last_d, flast_q, flast_d, zero_q, zero_d, flip_q, flip_d;
  logic none_q, none_d, ready_q, ready_d;
  logic neg_re_q, neg_re_d, neg_im_q, neg_im_d;
  logic signed [bop_pkg::PSIW-1:0] re_q, re_d, im_q, im_d;
  logic [SQW-1:0] mr_q, mr_d, mi_q, mi_d;
  logic [ACW-1:0] ar_q, ar_d, ai_q, ai_d, acc_q, acc_d;
  logic [SCW-1:0] sqc_q, sqc_d;

  logic ov_q, ov_d;
  logic signed [bop_pkg::PSIW-1:0] ore_q, ore_d, oim_q, oim_d;
  logic [bop_pkg::MAGW-1:0] omag_q, omag_d;
  logic oliq_q, oliq_d, onone_q, onone_d, ofe_q, ofe_d;
  logic [bop_pkg::OCNTW-1:0] ocnt_q, ocnt_d;

  bop_pkg::cordic_ctl_t cctl;
  logic signed [bop_pkg::CW-1:0] cx_in, cy_in, cx, cy, dxe, dye, xr, yr;
  logic signed [bop_pkg::ZW-1:0] cz_in, cz, t;
  logic cdone;
  logic [bop_pkg::ANGW-1:0] ang;
  logic [bop_pkg::ANGW+bop_pkg::SYMW-1:0] prod;
  logic signed [bop_pkg::PSIW-1:0] cs, sn;

  logic dstart, ddone, ddone_im;
  logic [DVW-1:0] dvd_re, dvd_im, q_re, q_im;
  logic signed [bop_pkg::SUMW-1:0] abs_re, abs_im;

  logic accept, last_in, load;
  logic [ACW-1:0] rnd;
  logic [bop_pkg::MAGW+1:0] magt;
  logic [bop_pkg::MAGW-1:0] mag;
  logic liquid;

  bop_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .ctl_i(cctl), .x_i(cx_in), .y_i(cy_in), .z_i(cz_in),
    .done_o(cdone), .x_o(cx), .y_o(cy), .z_o(cz)
  );

  bop_div #(.DW(DVW), .VW(BCW)) u_div_re (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(dvd_re), .divisor_i(bcnt_q),
    .done_o(ddone), .quot_o(q_re)
  );

  bop_div #(.DW(DVW), .VW(BCW)) u_div_im (
    .clk_i, .rst_ni, .start_i(dstart), .dividend_i(dvd_im), .divisor_i(bcnt_q),
    .done_o(ddone_im), .quot_o(q_im)
  );

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign last_in = particle_last_i || frame_last_i;

  always_comb begin
    dxe = bop_pkg::CW'(bond_dx_i);
    dye = bop_pkg::CW'(bond_dy_i);
    ang = zero_q ? '0 : cz[bop_pkg::ANGW-1:0];
    prod = (bop_pkg::ANGW + bop_pkg::SYMW)'(ang) * (bop_pkg::ANGW + bop_pkg::SYMW)'(sym_q);
    t = bop_pkg::ZW'($signed(prod[bop_pkg::ANGW-1:0]));
    xr = flip_q ? -cx : cx;
    yr = flip_q ? -cy : cy;
    cs = clamp_unit(xr);
    sn = clamp_unit(yr);
    abs_re = sre_q[bop_pkg::SUMW-1] ? -sre_q : sre_q;
    abs_im = sim_q[bop_pkg::SUMW-1] ? -sim_q : sim_q;
    dvd_re = DVW'(abs_re) + DVW'(bcnt_q >> 1);
    dvd_im = DVW'(abs_im) + DVW'(bcnt_q >> 1);
    rnd = acc_q + ACW'(32768);
    magt = (bop_pkg::MAGW + 2)'(rnd >> 16);
    mag = (magt > (bop_pkg::MAGW + 2)'(65536)) ? bop_pkg::MAGW'(65536)
                                               : magt[bop_pkg::MAGW-1:0];
    liquid = !none_q && (mag < thr_q);
    lnew = (liquid && lcnt_q < LCAP) ? lcnt_q + 1'b1 : lcnt_q;
  end

  always_comb begin
    state_d = state_q;
    cctl = '0;
    cx_in = '0;
    cy_in = '0;
    cz_in = '0;
    dstart = 1'b0;
    load = 1'b0;
    sre_d = sre_q;  sim_d = sim_q;  bcnt_d = bcnt_q;  lcnt_d = lcnt_q;
    last_d = last_q;  flast_d = flast_q;  zero_d = zero_q;  flip_d = flip_q;
    none_d = none_q;  ready_d = ready_q;
    neg_re_d = neg_re_q;  neg_im_d = neg_im_q;
    re_d = re_q;  im_d = im_q;
    mr_d = mr_q;  mi_d = mi_q;  ar_d = ar_q;  ai_d = ai_q;  acc_d = acc_q;
    sqc_d = sqc_q;
    ov_d = ov_q && out_stall_i;
    ore_d = ore_q;  oim_d = oim_q;  omag_d = omag_q;  oliq_d = oliq_q;
    onone_d = onone_q;  ofe_d = ofe_q;  ocnt_d = ocnt_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = last_in;
          flast_d = frame_last_i;
          ready_d = 1'b0;
          if (bond_valid_i && bcnt_q < BCW'(MAX_NEIGHBOURS)) begin
            zero_d = (bond_dx_i == '0) && (bond_dy_i == '0);
            cctl.start = 1'b1;
            cctl.vectoring = 1'b1;
            if (bond_dx_i[bop_pkg::DXW-1]) begin
              cx_in = -dxe;
              cy_in = -dye;
              cz_in = 19'sd65536;
            end else begin
              cx_in = dxe;
              cy_in = dye;
            end
            state_d = ST_VEC;
          end else if (last_in) begin
            state_d = ST_END;
          end
        end
      end
      ST_VEC: begin
        if (cdone) begin
          // Fold the multiplied angle into a half turn around zero.
          cctl.start = 1'b1;
          cx_in = bop_pkg::CORDIC_GAIN;
          if (t > 19'sd32768) begin
            cz_in = t - 19'sd65536;
            flip_d = 1'b1;
          end else if (t < -19'sd32768) begin
            cz_in = t + 19'sd65536;
            flip_d = 1'b1;
          end else begin
            cz_in = t;
            flip_d = 1'b0;
          end
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (cdone) begin
          sre_d = sre_q + bop_pkg::SUMW'(cs);
          sim_d = sim_q + bop_pkg::SUMW'(sn);
          bcnt_d = bcnt_q + 1'b1;
          state_d = last_q ? ST_END : ST_IDLE;
        end
      end
      ST_END: begin
        if (!ready_q) begin
          if (bcnt_q == '0) begin
            none_d = 1'b1;
            acc_d = '0;
            re_d = '0;
            im_d = '0;
            ready_d = 1'b1;
          end else begin
            none_d = 1'b0;
            neg_re_d = sre_q[bop_pkg::SUMW-1];
            neg_im_d = sim_q[bop_pkg::SUMW-1];
            dstart = 1'b1;
            state_d = ST_DIV;
          end
        end else if (!ov_q || !out_stall_i) begin
          load = 1'b1;
          ov_d = 1'b1;
          ore_d = re_q;
          oim_d = im_q;
          omag_d = none_q ? '0 : mag;
          oliq_d = liquid;
          onone_d = none_q;
          ofe_d = flast_q;
          ocnt_d = flast_q ? bop_pkg::OCNTW'(lnew) : '0;
          lcnt_d = flast_q ? '0 : lnew;
          sre_d = '0;
          sim_d = '0;
          bcnt_d = '0;
          ready_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (ddone) begin
          re_d = neg_re_q ? -bop_pkg::PSIW'(q_re) : bop_pkg::PSIW'(q_re);
          im_d = neg_im_q ? -bop_pkg::PSIW'(q_im) : bop_pkg::PSIW'(q_im);
          mr_d = q_re[SQW-1:0];
          mi_d = q_im[SQW-1:0];
          ar_d = ACW'(q_re[SQW-1:0]);
          ai_d = ACW'(q_im[SQW-1:0]);
          acc_d = '0;
          sqc_d = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        // Shift-and-add squaring, one multiplier bit of each mean per cycle.
        acc_d = acc_q + (mr_q[0] ? ar_q : '0) + (mi_q[0] ? ai_q : '0);
        mr_d = mr_q >> 1;
        mi_d = mi_q >> 1;
        ar_d = ar_q << 1;
        ai_d = ai_q << 1;
        sqc_d = sqc_q + 1'b1;
        if (sqc_q == SQ_LAST) begin
          ready_d = 1'b1;
          state_d = ST_END;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sym_q   <= bop_pkg::SYM_RESET;
      thr_q   <= bop_pkg::THR_RESET;
      sre_q   <= '0;
      sim_q   <= '0;
      bcnt_q  <= '0;
      lcnt_q  <= '0;
      ready_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sre_q   <= sre_d;
      sim_q   <= sim_d;
      bcnt_q  <= bcnt_d;
      lcnt_q  <= lcnt_d;
      ready_q <= ready_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          bop_pkg::REG_SYMMETRY:  sym_q <= cfg_wdata_i[bop_pkg::SYMW-1:0];
          bop_pkg::REG_THRESHOLD: thr_q <= cfg_wdata_i[bop_pkg::THRW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;  flast_q <= flast_d;  zero_q <= zero_d;  flip_q <= flip_d;
    none_q <= none_d;  neg_re_q <= neg_re_d;  neg_im_q <= neg_im_d;
    re_q <= re_d;  im_q <= im_d;
    mr_q <= mr_d;  mi_q <= mi_d;  ar_q <= ar_d;  ai_q <= ai_d;  acc_q <= acc_d;
    sqc_q <= sqc_d;
    ore_q <= ore_d;  oim_q <= oim_d;  omag_q <= omag_d;  oliq_q <= oliq_d;
    onone_q <= onone_d;  ofe_q <= ofe_d;  ocnt_q <= ocnt_d;
  end

  assign out_valid_o          = ov_q;
  assign psi_real_o           = ore_q;
  assign psi_imag_o           = oim_q;
  assign psi_mag_sq_o         = omag_q;
  assign is_liquid_o          = oliq_q;
  assign no_neighbours_o      = onone_q;
  assign frame_end_o          = ofe_q;
  assign frame_liquid_count_o = ocnt_q;

  a_bond_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bcnt_q <= BCW'(MAX_NEIGHBOURS))
    else $error("bond count beyond the neighbour limit");

  a_cordic_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (state_q == ST_VEC || state_q == ST_ROT))
    else $error("CORDIC finished outside a bond pass");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddone == ddone_im)
    else $error("the two dividers finished in different cycles");

  a_clear_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (bcnt_q == '0 && sre_q == '0 && sim_q == '0 && out_valid_o))
    else $error("particle state not cleared after a result transfer");

  a_empty_particle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && no_neighbours_o) |-> (psi_mag_sq_o == '0 && !is_liquid_o))
    else $error("particle without bonds reported a nonzero order");

endmodule

>>> design/bop_cordic.sv
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotating mode.
// Depends on bop_pkg.
module bop_cordic #(
  parameter int STEPS = bop_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bop_pkg::cordic_ctl_t              ctl_i,
  input  logic signed [bop_pkg::CW-1:0]     x_i,
  input  logic signed [bop_pkg::CW-1:0]     y_i,
  input  logic signed [bop_pkg::ZW-1:0]     z_i,
  output logic                              done_o,
  output logic signed [bop_pkg::CW-1:0]     x_o,
  output logic signed [bop_pkg::CW-1:0]     y_o,
  output logic signed [bop_pkg::ZW-1:0]     z_o
);

  localparam int SW = $clog2(STEPS + 1);
  localparam logic [SW-1:0] LAST = SW'(STEPS - 1);

  logic signed [bop_pkg::CW-1:0] x_q, x_d, y_q, y_d, xs, ys;
  logic signed [bop_pkg::ZW-1:0] z_q, z_d, at;
  logic [SW-1:0] step_q, step_d;
  logic busy_q, busy_d, done_q, done_d, vec_q, vec_d, cw;

  always_comb begin
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
    at = bop_pkg::ZW'(bop_pkg::atan_lut(bop_pkg::ATAN_IW'(step_q)));
    // Vectoring drives y to zero, rotation drives the residual angle to zero.
    cw = vec_q ? !y_q[bop_pkg::CW-1] : z_q[bop_pkg::ZW-1];
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    step_d = step_q;
    busy_d = busy_q;
    vec_d = vec_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
      step_d = '0;
      busy_d = 1'b1;
      vec_d = ctl_i.vectoring;
    end else if (busy_q) begin
      if (cw) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end
      step_d = step_q + 1'b1;
      if (step_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      vec_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      vec_q  <= vec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

>>> design/bop_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its parameters.
module bop_div #(
  parameter int DW = 22,
  parameter int VW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int NW = $clog2(DW + 1);
  localparam logic [NW-1:0] LAST = NW'(DW - 1);

  logic [DW-1:0] sh_q, sh_d;
  logic [VW-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [VW:0]   trial, diff;
  logic [NW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d, ge;

  always_comb begin
    trial = {rem_q, sh_q[DW-1]};
    ge = trial >= {1'b0, dv_q};
    diff = trial - {1'b0, dv_q};
    sh_d = sh_q;
    rem_d = rem_q;
    dv_d = dv_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d = dividend_i;
      rem_d = '0;
      dv_d = divisor_i;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d = {sh_q[DW-2:0], ge};
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    dv_q  <= dv_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

>>> dv/tb.sv
// Testbench for the bond orientational order block: directed and random bond
// streams, with a built-in predictor and an in-order result checker.
// Depends on bop_pkg and bond_orientational_order.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic signed [bop_pkg::DXW-1:0] dx;
    logic signed [bop_pkg::DXW-1:0] dy;
    logic                  has_bond;
    logic                  p_last;
    logic                  f_last;
  } bond_item_t;

  typedef struct {
    logic signed [bop_pkg::PSIW-1:0] re;
    logic signed [bop_pkg::PSIW-1:0] im;
    logic [bop_pkg::MAGW-1:0]        mag;
    logic                   liquid;
    logic                   lonely;
    logic                   f_end;
    logic [bop_pkg::OCNTW-1:0]       f_count;
  } psi_result_t;

  localparam int MAX_BONDS = 15;
  localparam int STEPS     = 16;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE    = 200;

  const int arctan_steps[16] = '{16384, 9672, 5110, 2594, 1302, 652, 326, 163,
                                 81, 41, 20, 10, 5, 3, 1, 1};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [bop_pkg::CFG_AW-1:0] cfg_addr_i = '0;
  logic [bop_pkg::CFG_DW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [bop_pkg::DXW-1:0] bond_dx_i = '0;
  logic signed [bop_pkg::DXW-1:0] bond_dy_i = '0;
  logic bond_valid_i = 1'b0;
  logic particle_last_i = 1'b0;
  logic frame_last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic signed [bop_pkg::PSIW-1:0] psi_real_o;
  logic signed [bop_pkg::PSIW-1:0] psi_imag_o;
  logic [bop_pkg::MAGW-1:0] psi_mag_sq_o;
  logic is_liquid_o;
  logic no_neighbours_o;
  logic frame_end_o;
  logic [bop_pkg::OCNTW-1:0] frame_liquid_count_o;

  bond_orientational_order dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state.
  logic [bop_pkg::SYMW-1:0] sym_order;
  logic [bop_pkg::THRW-1:0] thr_sq;
  longint acc_re, acc_im;
  int nbonds;
  int liquid_seen;

  psi_result_t psi_pending[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [bop_pkg::ANGW-1:0] bond_angle(longint x, longint y);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 65536;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += arctan_steps[i];
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= arctan_steps[i];
      end
      x = nx;
      y = ny;
    end
    return z[bop_pkg::ANGW-1:0];
  endfunction

  function automatic longint to_unit(longint v);
    v = (v + 128) >>> 8;
    if (v > 65536) v = 65536;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  function automatic void rotate_unit(logic [bop_pkg::ANGW-1:0] ang, output longint c,
                                      output longint s);
    longint t, x, y, nx, ny;
    bit flip;
    t = ang;
    if (ang[bop_pkg::ANGW-1]) t -= 131072;
    x = 10188014;
    y = 0;
    flip = 0;
    if (t > 32768) begin
      t -= 65536;
      flip = 1;
    end else if (t < -32768) begin
      t += 65536;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        t -= arctan_steps[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        t += arctan_steps[i];
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = to_unit(x);
    s = to_unit(y);
  endfunction

  function automatic longint mean_rounded(longint s, int c);
    longint a, q;
    a = (s < 0) ? -s : s;
    q = (a + c / 2) / c;
    return (s < 0) ? -q : q;
  endfunction

  function automatic void predict_psi(bond_item_t it);
    logic [bop_pkg::ANGW-1:0] a, th;
    logic [bop_pkg::ANGW+bop_pkg::SYMW-1:0] prod;
    longint c, s, re, im, mag;
    psi_result_t r;
    if (it.has_bond && nbonds < MAX_BONDS) begin
      a = bond_angle(longint'(it.dx), longint'(it.dy));
      prod = a * sym_order;
      th = prod[bop_pkg::ANGW-1:0];
      rotate_unit(th, c, s);
      acc_re += c;
      acc_im += s;
      nbonds++;
    end
    if (!it.p_last && !it.f_last) return;
    re = 0;
    im = 0;
    mag = 0;
    r.liquid = 1'b0;
    r.lonely = (nbonds == 0);
    if (nbonds != 0) begin
      re = mean_rounded(acc_re, nbonds);
      im = mean_rounded(acc_im, nbonds);
      mag = (re * re + im * im + 32768) >>> 16;
      if (mag > 65536) mag = 65536;
      r.liquid = (mag < thr_sq);
      if (r.liquid && liquid_seen < 65535) liquid_seen++;
    end
    acc_re = 0;
    acc_im = 0;
    nbonds = 0;
    r.f_end = it.f_last;
    r.f_count = '0;
    if (it.f_last) begin
      r.f_count = liquid_seen[bop_pkg::OCNTW-1:0];
      liquid_seen = 0;
    end
    r.re = re[bop_pkg::PSIW-1:0];
    r.im = im[bop_pkg::PSIW-1:0];
    r.mag = mag[bop_pkg::MAGW-1:0];
    psi_pending.push_back(r);
  endfunction

  // Sends one item after a random gap and waits for its transfer.
  task automatic send_bond(bond_item_t it);
    int gap;
    gap = $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    bond_dx_i = it.dx;
    bond_dy_i = it.dy;
    bond_valid_i = it.has_bond;
    particle_last_i = it.p_last;
    frame_last_i = it.f_last;
    in_valid_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_psi(it);
  endtask

  task automatic end_items();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic bond_item_t make_bond(longint dx, longint dy, bit pl, bit fl);
    bond_item_t it;
    it.dx = dx[bop_pkg::DXW-1:0];
    it.dy = dy[bop_pkg::DXW-1:0];
    it.has_bond = 1'b1;
    it.p_last = pl;
    it.f_last = fl;
    return it;
  endfunction

  function automatic logic signed [bop_pkg::DXW-1:0] rand_offset();
    logic [bop_pkg::DXW-1:0] v;
    v = bop_pkg::DXW'($urandom);
    v = v >> $urandom_range(0, bop_pkg::DXW - 1);
    if ($urandom_range(0, 1) != 0) v = -v;
    if ($urandom_range(0, 15) == 0) v = bop_pkg::DXW'($urandom);
    return v;
  endfunction

  // Waits until every result has arrived and the block has gone quiet.
  task automatic drain();
    end_items();
    wait (psi_pending.size() == 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [bop_pkg::CFG_AW-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_addr_i = idx;
    cfg_wdata_i = val[bop_pkg::CFG_DW-1:0];
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == bop_pkg::REG_SYMMETRY) sym_order = val[bop_pkg::SYMW-1:0];
    else thr_sq = val[bop_pkg::THRW-1:0];
  endtask

  task automatic test_directed();
    bond_item_t it;
    send_bond(make_bond(0, 0, 1, 0));                   // zero offset
    send_bond(make_bond(8388607, 8388607, 0, 0));
    send_bond(make_bond(-8388608, -8388608, 0, 0));
    send_bond(make_bond(-8388608, 8388607, 0, 0));
    send_bond(make_bond(8388607, -8388608, 1, 0));
    send_bond(make_bond(-4096, 0, 0, 0));
    send_bond(make_bond(0, 4096, 0, 0));
    send_bond(make_bond(0, -4096, 1, 0));
    it = make_bond(0, 0, 1, 0);
    it.has_bond = 1'b0;
    send_bond(it);                                     // particle with no bonds
    it.p_last = 1'b0;
    send_bond(it);                                     // ignored item
    send_bond(make_bond(4096, 4096, 0, 1));            // frame end alone
    it.f_last = 1'b1;
    send_bond(it);                                     // empty particle closing a frame
    for (int i = 0; i < 18; i++)                       // more bonds than allowed
      send_bond(make_bond(rand_offset(), rand_offset(), i == 17, i == 17));
  endtask

  task automatic test_random(int n_items);
    bond_item_t it;
    int k, len;
    k = 0;
    while (k < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: stray items without a bond and broken particles.
        it = make_bond(rand_offset(), rand_offset(), $urandom_range(0, 1) != 0,
                       $urandom_range(0, 3) == 0);
        it.has_bond = 1'b0;
        send_bond(it);
        if (it.p_last || it.f_last) k++;
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 18) : $urandom_range(1, 7);
        for (int i = 0; i < len; i++) begin
          it = make_bond(rand_offset(), rand_offset(), i == len - 1,
                         (i == len - 1) && ($urandom_range(0, 4) == 0));
          if ($urandom_range(0, 19) == 0) it.has_bond = 1'b0;
          send_bond(it);
          k++;
        end
      end
    end
  endtask

  task automatic test_registers();
    write_reg(bop_pkg::REG_SYMMETRY, 0);
    write_reg(bop_pkg::REG_THRESHOLD, 65536);
    test_random(60);
    drain();
    write_reg(bop_pkg::REG_SYMMETRY, 15);
    write_reg(bop_pkg::REG_THRESHOLD, 0);
    test_random(60);
    drain();
    write_reg(bop_pkg::REG_SYMMETRY, 1);
    write_reg(bop_pkg::REG_THRESHOLD, 131071);
    test_random(60);
    drain();
    write_reg(bop_pkg::REG_SYMMETRY, 12);
    write_reg(bop_pkg::REG_THRESHOLD, 40000);
    test_random(60);
    drain();
    write_reg(bop_pkg::REG_SYMMETRY, 4);
    write_reg(bop_pkg::REG_THRESHOLD, 1000);
    test_random(60);
    drain();
  endtask

  // Result side: random stall before each transfer, then an in-order check.
  initial begin
    psi_result_t exp_r;
    int wait_cycles;
    forever begin
      wait_cycles = $urandom_range(0, 7);
      @(negedge clk_i);
      out_stall_i = (wait_cycles != 0);
      repeat (wait_cycles) @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!(rst_ni && out_valid_o));
      if (psi_pending.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d", $time, psi_real_o, psi_imag_o);
        errors++;
      end else begin
        exp_r = psi_pending.pop_front();
        if (psi_real_o !== exp_r.re || psi_imag_o !== exp_r.im ||
            psi_mag_sq_o !== exp_r.mag || is_liquid_o !== exp_r.liquid ||
            no_neighbours_o !== exp_r.lonely || frame_end_o !== exp_r.f_end ||
            frame_liquid_count_o !== exp_r.f_count) begin
          $display("%0t: expected re=%0d im=%0d mag=%0d liq=%0b none=%0b fe=%0b cnt=%0d",
                   $time, exp_r.re, exp_r.im, exp_r.mag, exp_r.liquid, exp_r.lonely,
                   exp_r.f_end, exp_r.f_count);
          $display("%0t: actual   re=%0d im=%0d mag=%0d liq=%0b none=%0b fe=%0b cnt=%0d",
                   $time, psi_real_o, psi_imag_o, psi_mag_sq_o, is_liquid_o,
                   no_neighbours_o, frame_end_o, frame_liquid_count_o);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    sym_order = bop_pkg::SYM_RESET;
    thr_sq = bop_pkg::THR_RESET;
    acc_re = 0;
    acc_im = 0;
    nbonds = 0;
    liquid_seen = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    drain();
    test_registers();
    write_reg(bop_pkg::REG_SYMMETRY, 6);
    write_reg(bop_pkg::REG_THRESHOLD, 16384);
    test_random(700);
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> bond_orientational_order.f
design/bop_pkg.sv
design/bop_cordic.sv
design/bop_div.sv
design/bond_orientational_order.sv
dv/tb.sv
